FILE: rtl/qis_pkg.sv
// ----------------------------------------------------------------------------
// qis_pkg
// Shared types and constants of the qualified identifier splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package qis_pkg;

	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned NAME_LEN_W      = 8;
	localparam int unsigned MAX_NAME_LEN_DF = 63;
	localparam int unsigned QUEUE_DEPTH     = 2;
	localparam logic [BYTE_W-1:0] SEP_RESET = 8'h2E;

	localparam logic [BYTE_W-1:0] CH_END      = 8'h00;
	localparam logic [BYTE_W-1:0] CH_BACKTICK = 8'h60;
	localparam logic [BYTE_W-1:0] CH_UPPER_A  = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

	// one output record
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              name_end;
		logic              list_done;
		logic              syntax_error;
	} qis_result_t;

	// space, tab, newline, carriage return, form feed, vertical tab
	function automatic logic is_ws(input logic [BYTE_W-1:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
			c == 8'h0C || c == 8'h0B;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/qis_front.sv
// ----------------------------------------------------------------------------
// qis_front
// Accepts bytes, runs the parse state machine and pushes result records.
// ----------------------------------------------------------------------------
`default_nettype none

module qis_front import qis_pkg::*; #(
	parameter int unsigned MAX_NAME_LEN = MAX_NAME_LEN_DF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic [BYTE_W-1:0] sep_char,
	input  wire logic              q_full,
	output logic                   push,
	output qis_result_t            push_data
);

	localparam logic [2:0] M_LEAD      = 3'd0;
	localparam logic [2:0] M_UNQ       = 3'd1;
	localparam logic [2:0] M_QUOTED    = 3'd2;
	localparam logic [2:0] M_QSEEN     = 3'd3;
	localparam logic [2:0] M_TRAIL     = 3'd4;
	localparam logic [2:0] M_AFTER_SEP = 3'd5;
	localparam logic [2:0] M_FAILED    = 3'd6;

	localparam logic [NAME_LEN_W-1:0] LEN_MAX = NAME_LEN_W'(MAX_NAME_LEN);

	logic [2:0]            mode_q, mode_d;
	logic [NAME_LEN_W-1:0] len_q, len_d;
	logic                  accept, emit;
	qis_result_t           res;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && emit;
	assign push_data = res;

	always_comb begin
		logic                  c_end, c_ws, c_bt, c_sep;
		logic [BYTE_W-1:0]     lc;
		logic                  do_start, do_after, do_fail, do_byte;
		logic [BYTE_W-1:0]     byte_val;
		logic [NAME_LEN_W-1:0] len_base;

		c_end = in_byte == CH_END;
		c_ws  = is_ws(in_byte);
		c_bt  = in_byte == CH_BACKTICK;
		c_sep = in_byte == sep_char;
		lc    = (in_byte >= CH_UPPER_A && in_byte <= CH_UPPER_Z) ?
			in_byte + CASE_OFFSET : in_byte;

		do_start = 1'b0;
		do_after = 1'b0;
		do_fail  = 1'b0;
		do_byte  = 1'b0;
		byte_val = in_byte;
		len_base = len_q;
		emit     = 1'b0;
		res      = '0;
		mode_d   = mode_q;
		len_d    = len_q;

		case (mode_q)
			M_LEAD: begin
				if (c_end) begin
					emit          = 1'b1;
					res.list_done = 1'b1;
					len_d         = '0;
				end else if (c_bt || !c_ws) begin
					do_start = 1'b1;
				end
			end
			M_AFTER_SEP: begin
				if (c_end) begin
					do_fail = 1'b1;
				end else if (c_bt || !c_ws) begin
					do_start = 1'b1;
				end
			end
			M_UNQ: begin
				if (c_end || c_ws || c_sep) begin
					do_after = 1'b1;
				end else begin
					do_byte  = 1'b1;
					byte_val = lc;
				end
			end
			M_QUOTED: begin
				if (c_end) begin
					do_fail = 1'b1;
				end else if (c_bt) begin
					mode_d = M_QSEEN;
				end else begin
					do_byte = 1'b1;
				end
			end
			M_QSEEN: begin
				if (c_bt) begin
					mode_d  = M_QUOTED;
					do_byte = 1'b1;
				end else begin
					do_after = 1'b1;
				end
			end
			M_TRAIL: begin
				do_after = 1'b1;
			end
			default: begin
				// failed: drop bytes until the end byte
				if (c_end) begin
					mode_d = M_LEAD;
					len_d  = '0;
				end else begin
					mode_d = M_FAILED;
				end
			end
		endcase

		if (do_start) begin
			len_base = '0;
			len_d    = '0;
			if (c_bt) begin
				mode_d = M_QUOTED;
			end else if (c_sep) begin
				do_fail = 1'b1;
			end else begin
				mode_d   = M_UNQ;
				do_byte  = 1'b1;
				byte_val = lc;
			end
		end

		if (do_after) begin
			if (c_end) begin
				mode_d        = M_LEAD;
				len_d         = '0;
				emit          = 1'b1;
				res.name_end  = 1'b1;
				res.list_done = 1'b1;
			end else if (c_ws) begin
				mode_d = M_TRAIL;
			end else if (c_sep) begin
				mode_d       = M_AFTER_SEP;
				len_d        = '0;
				emit         = 1'b1;
				res.name_end = 1'b1;
			end else begin
				do_fail = 1'b1;
			end
		end

		if (do_fail) begin
			mode_d           = c_end ? M_LEAD : M_FAILED;
			len_d            = '0;
			emit             = 1'b1;
			res              = '0;
			res.syntax_error = 1'b1;
		end

		// bytes past the length limit are dropped silently
		if (do_byte && !do_fail && len_base < LEN_MAX) begin
			len_d          = len_base + 1'b1;
			emit           = 1'b1;
			res.out_byte   = byte_val;
			res.byte_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_LEAD;
			len_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			len_q  <= len_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/qis_queue.sv
// ----------------------------------------------------------------------------
// qis_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qis_queue import qis_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qis_result_t push_data,
	input  wire logic  pop,
	output qis_result_t pop_data,
	output logic       full,
	output logic       not_empty
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	qis_result_t      entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_FULL;
	assign not_empty = count_q != '0;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/qis_back.sv
// ----------------------------------------------------------------------------
// qis_back
// Output register: drains the result queue into the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module qis_back import qis_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_not_empty,
	input  wire qis_result_t       q_data,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   byte_valid,
	output logic                   name_end,
	output logic                   list_done,
	output logic                   syntax_error
);

	logic        valid_q;
	qis_result_t data_q;

	// load whenever the register is empty or its transaction completes
	assign pop = q_not_empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_data;
		end
	end

	assign out_valid    = valid_q;
	assign out_byte     = data_q.out_byte;
	assign byte_valid   = data_q.byte_valid;
	assign name_end     = data_q.name_end;
	assign list_done    = data_q.list_done;
	assign syntax_error = data_q.syntax_error;

endmodule

`default_nettype wire

FILE: rtl/qualified_identifier_splitter.sv
// ----------------------------------------------------------------------------
// qualified_identifier_splitter
// Splits a byte stream of qualified identifiers into names, one byte a cycle while in_stall is low.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with in_byte; a byte of 0 ends a string.
// Output channel: out_valid / out_stall with out_byte, byte_valid, name_end,
// list_done and syntax_error. A byte may give one record or none (whitespace,
// quote marks, bytes past the length limit, bytes after an error).
// Separator register: sep_char is written by cfg_we / cfg_wdata; the user
// must write it only while the block is idle, as the block itself does not
// enforce this. It resets to '.'.
// Throughput: one byte per cycle while in_stall is low, set by the parse state machine.
// Records go from the parser into the queue, then into the output register.
// When the receiver stalls, the output register holds, the two-entry queue
// fills, and in_stall rises only once the queue is full.
// Reset clears the parse state, the queue and the output valid; sep_char
// returns to '.'.
// ----------------------------------------------------------------------------
`default_nettype none

module qualified_identifier_splitter import qis_pkg::*; #(
	parameter int unsigned MAX_NAME_LEN = MAX_NAME_LEN_DF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [BYTE_W-1:0] cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] in_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   byte_valid,
	output logic                   name_end,
	output logic                   list_done,
	output logic                   syntax_error
);

	logic [BYTE_W-1:0] sep_q;
	logic              push, pop, q_full, q_not_empty;
	qis_result_t       push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= SEP_RESET;
		end else if (cfg_we) begin
			sep_q <= cfg_wdata;
		end
	end

	qis_front #(
		.MAX_NAME_LEN(MAX_NAME_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.sep_char (sep_q),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	qis_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (q_full),
		.not_empty(q_not_empty)
	);

	qis_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.name_end    (name_end),
		.list_done   (list_done),
		.syntax_error(syntax_error)
	);

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the qualified identifier splitter.
// ----------------------------------------------------------------------------
// Identifier lists go in one byte per transaction: a few hand-picked strings
// first, then random lists. Most random lists are well formed. Some are
// broken or replaced with noise. The separator is rewritten between phases.
// A parser model in this file predicts each output record. The monitor
// compares every record field by field, in order, with the predicted one.
// Both sides insert random bubbles. The receiver also holds off for long
// stretches, so the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top import qis_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		MODE_LEAD,
		MODE_BARE,
		MODE_QUOTED,
		MODE_QUOTE_SEEN,
		MODE_TRAIL,
		MODE_AFTER_SEP,
		MODE_FAILED
	} parse_mode_t;

	localparam int unsigned IDLE_PCT  = 28;
	localparam int unsigned HOLD_LEN  = 80;
	localparam int unsigned PHASE_LEN = 210;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_we       = 1'b0;
	logic [BYTE_W-1:0] cfg_wdata    = '0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] in_byte      = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_valid;
	logic              name_end;
	logic              list_done;
	logic              syntax_error;

	// parser model state
	parse_mode_t       mode     = MODE_LEAD;
	int unsigned       name_len = 0;
	logic [BYTE_W-1:0] sep      = SEP_RESET;

	logic [BYTE_W-1:0] byte_stream[$];
	logic [BYTE_W-1:0] line_buf[$];
	qis_result_t       pending_records[$];
	qis_result_t       got_rec;
	qis_result_t       want_rec;
	qis_result_t       new_rec;
	int unsigned       mismatches = 0;
	bit                in_taken   = 1'b0;
	bit                steady     = 1'b0;
	int unsigned       rx_cycles  = 0;
	int unsigned       hold_left  = 0;

	qualified_identifier_splitter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.name_end    (name_end),
		.list_done   (list_done),
		.syntax_error(syntax_error)
	);

	always #5 clk = ~clk;

	function automatic bit is_blank(input logic [BYTE_W-1:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
			c == 8'h0C || c == 8'h0B;
	endfunction

	function automatic bit flag_error(input logic [BYTE_W-1:0] c, output qis_result_t rec);
		rec = '0;
		rec.syntax_error = 1'b1;
		mode = (c == CH_END) ? MODE_LEAD : MODE_FAILED;
		name_len = 0;
		return 1'b1;
	endfunction

	// bytes past the length limit are dropped silently
	function automatic bit add_name_byte(input logic [BYTE_W-1:0] c, output qis_result_t rec);
		rec = '0;
		if (name_len >= MAX_NAME_LEN_DF)
			return 1'b0;
		name_len++;
		rec.out_byte = c;
		rec.byte_valid = 1'b1;
		return 1'b1;
	endfunction

	function automatic bit close_name(input logic [BYTE_W-1:0] c, output qis_result_t rec);
		rec = '0;
		if (c == CH_END) begin
			mode = MODE_LEAD;
			name_len = 0;
			rec.name_end = 1'b1;
			rec.list_done = 1'b1;
			return 1'b1;
		end
		if (is_blank(c)) begin
			mode = MODE_TRAIL;
			return 1'b0;
		end
		if (c == sep) begin
			mode = MODE_AFTER_SEP;
			name_len = 0;
			rec.name_end = 1'b1;
			return 1'b1;
		end
		return flag_error(c, rec);
	endfunction

	// advances the parser model by one byte; returns 1 when a record is due
	function automatic bit split_byte(input logic [BYTE_W-1:0] c, output qis_result_t rec);
		logic [BYTE_W-1:0] folded;
		bit                due;
		rec = '0;
		due = 1'b0;
		folded = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
		case (mode)
			MODE_LEAD, MODE_AFTER_SEP: begin
				if (c == CH_END) begin
					if (mode == MODE_LEAD) begin
						name_len = 0;
						rec.list_done = 1'b1;
						due = 1'b1;
					end else begin
						due = flag_error(c, rec);
					end
				end else if (c == CH_BACKTICK) begin
					name_len = 0;
					mode = MODE_QUOTED;
				end else if (is_blank(c)) begin
					due = 1'b0;
				end else if (c == sep) begin
					due = flag_error(c, rec);
				end else begin
					name_len = 0;
					mode = MODE_BARE;
					due = add_name_byte(folded, rec);
				end
			end
			MODE_BARE: begin
				if (c == CH_END || is_blank(c) || c == sep)
					due = close_name(c, rec);
				else
					due = add_name_byte(folded, rec);
			end
			MODE_QUOTED: begin
				if (c == CH_END)
					due = flag_error(c, rec);
				else if (c == CH_BACKTICK)
					mode = MODE_QUOTE_SEEN;
				else
					due = add_name_byte(c, rec);
			end
			MODE_QUOTE_SEEN: begin
				// doubled backtick stands for one backtick
				if (c == CH_BACKTICK) begin
					mode = MODE_QUOTED;
					due = add_name_byte(c, rec);
				end else begin
					due = close_name(c, rec);
				end
			end
			MODE_TRAIL: begin
				due = close_name(c, rec);
			end
			default: begin
				if (c == CH_END) begin
					mode = MODE_LEAD;
					name_len = 0;
				end
			end
		endcase
		return due;
	endfunction

	task automatic check_field(input string field, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endtask

	// sender: a byte stays offered until taken
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (byte_stream.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				in_byte <= byte_stream.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus two long hold-offs
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycles <= rx_cycles + 1;
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (rx_cycles == 400 || rx_cycles == 1500) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_LEN - 1;
			end else begin
				out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// monitor: predict on each input transaction, check each output one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				if (split_byte(in_byte, new_rec))
					pending_records.push_back(new_rec);
			if (out_valid && !out_stall) begin
				got_rec = '{out_byte, byte_valid, name_end, list_done, syntax_error};
				if (pending_records.size() == 0) begin
					$error("unexpected record: out_byte %0h flags %b%b%b%b", out_byte,
						byte_valid, name_end, list_done, syntax_error);
					mismatches++;
				end else begin
					want_rec = pending_records.pop_front();
					check_field("out_byte", want_rec.out_byte, got_rec.out_byte);
					check_field("byte_valid", want_rec.byte_valid, got_rec.byte_valid);
					check_field("name_end", want_rec.name_end, got_rec.name_end);
					check_field("list_done", want_rec.list_done, got_rec.list_done);
					check_field("syntax_error", want_rec.syntax_error, got_rec.syntax_error);
				end
			end
		end
	end

	function automatic logic [BYTE_W-1:0] pick_blank();
		case ($urandom_range(0, 5))
			0: return 8'h20;
			1: return 8'h09;
			2: return 8'h0A;
			3: return 8'h0D;
			4: return 8'h0C;
			default: return 8'h0B;
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_bare_char(input bit first);
		logic [BYTE_W-1:0] c;
		do begin
			case ($urandom_range(0, 3))
				0: c = BYTE_W'($urandom_range(8'h41, 8'h5A));
				1: c = BYTE_W'($urandom_range(8'h61, 8'h7A));
				2: c = BYTE_W'($urandom_range(8'h30, 8'h39));
				default: c = BYTE_W'($urandom_range(1, 255));
			endcase
		end while (is_blank(c) || c == sep || (first && c == CH_BACKTICK));
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] pick_quoted_char();
		logic [BYTE_W-1:0] c;
		do
			c = BYTE_W'($urandom_range(1, 255));
		while (c == CH_BACKTICK);
		return c;
	endfunction

	// one well-formed list: names, separators, optional blanks, end byte
	task automatic build_list();
		int unsigned n_names;
		int unsigned len;
		line_buf = {};
		n_names = $urandom_range(1, 4);
		if ($urandom_range(0, 3) == 0)
			line_buf.push_back(pick_blank());
		for (int k = 0; k < n_names; k++) begin
			if (k != 0) begin
				if ($urandom_range(0, 4) == 0)
					line_buf.push_back(pick_blank());
				line_buf.push_back(sep);
				if ($urandom_range(0, 4) == 0)
					line_buf.push_back(pick_blank());
			end
			// an occasional name runs past the length limit
			len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 8);
			if ($urandom_range(0, 2) == 0) begin
				line_buf.push_back(CH_BACKTICK);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 7) == 0) begin
						line_buf.push_back(CH_BACKTICK);
						line_buf.push_back(CH_BACKTICK);
					end else begin
						line_buf.push_back(pick_quoted_char());
					end
				end
				line_buf.push_back(CH_BACKTICK);
			end else begin
				if (len == 0)
					len = 1;
				for (int i = 0; i < len; i++)
					line_buf.push_back(pick_bare_char(i == 0));
			end
			if ($urandom_range(0, 3) == 0)
				line_buf.push_back(pick_blank());
		end
		line_buf.push_back(CH_END);
	endtask

	task automatic mangle_list();
		int unsigned n;
		case ($urandom_range(0, 3))
			0: line_buf[$urandom_range(0, line_buf.size() - 1)] = BYTE_W'($urandom_range(0, 255));
			1: line_buf.insert(line_buf.size() - 1, sep);
			2: line_buf.insert($urandom_range(0, line_buf.size() - 1),
				BYTE_W'($urandom_range(1, 255)));
			default: begin
				line_buf = {};
				n = $urandom_range(1, 12);
				repeat (n)
					line_buf.push_back(BYTE_W'($urandom_range(0, 255)));
				line_buf.push_back(CH_END);
			end
		endcase
	endtask

	task automatic wait_idle();
		while (byte_stream.size() != 0 || in_valid || pending_records.size() != 0)
			@(posedge clk);
		// records that never leave the parser still change its state
		repeat (4) @(posedge clk);
	endtask

	task automatic write_sep(input logic [BYTE_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		sep = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned target);
		int unsigned added;
		added = 0;
		while (added < target) begin
			build_list();
			if ($urandom_range(0, 99) < 25)
				mangle_list();
			added += line_buf.size();
			foreach (line_buf[i])
				byte_stream.push_back(line_buf[i]);
		end
	endtask

	initial begin
		// hand-picked strings, separator '.'
		byte_stream = '{
			8'h00,
			8'h09, 8'h41, 8'h5A, 8'h40, 8'h5B, 8'h60, 8'h2E, 8'h60, 8'h60, 8'h00,
			8'h60, 8'h61, 8'h60, 8'h60, 8'hFF, 8'h60, 8'h20, 8'h78, 8'h00,
			8'h2E, 8'h00,
			8'h61, 8'h2E, 8'h00,
			8'h60, 8'h00
		};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_phase(PHASE_LEN);
		write_sep(8'h01);
		run_phase(PHASE_LEN);
		write_sep(8'hFF);
		run_phase(PHASE_LEN);
		write_sep(8'h2C);
		steady = 1'b1;
		run_phase(PHASE_LEN);
		wait_idle();
		steady = 1'b0;
		write_sep(CH_BACKTICK);
		run_phase(PHASE_LEN / 2);
		write_sep(8'h20);
		run_phase(PHASE_LEN / 2);
		write_sep(BYTE_W'($urandom_range(1, 255)));
		run_phase(PHASE_LEN);
		write_sep(SEP_RESET);
		run_phase(PHASE_LEN);
		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#1000000;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
rtl/qis_pkg.sv
rtl/qis_front.sv
rtl/qis_queue.sv
rtl/qis_back.sv
rtl/qualified_identifier_splitter.sv
verif/tb_top.sv
